// ----- sv/dpws_pkg.sv -----
`default_nettype none

package dpws_pkg;

   // Sequence phases, in the order a weld walks through them
   typedef logic [2:0] phase_type;

   localparam phase_type PH_IDLE     = 3'd0;
   localparam phase_type PH_PREDELAY = 3'd1;
   localparam phase_type PH_PULSE1   = 3'd2;
   localparam phase_type PH_GAP      = 3'd3;
   localparam phase_type PH_PULSE2   = 3'd4;
   localparam phase_type PH_HOLDOFF  = 3'd5;

   // CSR indexes
   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_PRE_DELAY    = 3'd0;
   localparam csr_index_type CSR_FIRST_PULSE  = 3'd1;
   localparam csr_index_type CSR_GAP          = 3'd2;
   localparam csr_index_type CSR_SECOND_PULSE = 3'd3;
   localparam csr_index_type CSR_HOLDOFF      = 3'd4;
   localparam csr_index_type CSR_FIRST_LIMIT  = 3'd5;
   localparam csr_index_type CSR_SECOND_LIMIT = 3'd6;

   localparam int CSR_DATA_W = 10;
   localparam int TEMP_W     = 9;

   // CSR reset values
   localparam logic [9:0] RST_PRE_DELAY    = 10'd10;
   localparam logic [8:0] RST_FIRST_PULSE  = 9'd150;
   localparam logic [8:0] RST_GAP          = 9'd80;
   localparam logic [8:0] RST_SECOND_PULSE = 9'd100;
   localparam logic [9:0] RST_HOLDOFF      = 10'd500;
   localparam logic signed [8:0] RST_FIRST_LIMIT  = 9'sd45;
   localparam logic signed [8:0] RST_SECOND_LIMIT = 9'sd40;

   // Input word, lowest field last
   typedef struct packed {
      logic [3:0]               pad;
      logic signed [TEMP_W-1:0] second_sensor_temp;
      logic signed [TEMP_W-1:0] first_sensor_temp;
      logic                     armed;
      logic                     trigger;
   } req_word_type;

   // Result word, lowest field last
   typedef struct packed {
      logic [1:0] pad;
      phase_type  phase;
      logic       overheated;
      logic       busy_res;
      logic       weld_drive;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- sv/double_pulse_weld_sequencer_top.sv -----
`default_nettype none

// Double-pulse spot weld sequencer. Each accepted req word is one 1 ms tick
// carrying trigger, armed and two signed temperatures; each tick yields exactly
// one rsp word with weld_drive, busy, overheated and the phase after the tick.
// An armed trigger on an idle, cool tick starts pre-delay, pulse 1, gap,
// pulse 2 and hold-off; zero-length phases are skipped and the trigger tick is
// the first tick of the first non-empty phase. While a weld runs, triggers and
// temperatures are ignored. Rate: one word per clock cycle, sustained; the
// phase register and tick counter update on accept and the result lands in
// an output register, so req_tready stays high unless that register holds a
// word the consumer has not taken. A rsp word is valid the cycle after accept.
// CSRs are written through csr_wen/csr_index/csr_wdata and should only change
// while the block is idle; lengths are read live by a running sequence.
module double_pulse_weld_sequencer_top #(
   parameter int TIMER_BITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] trigger, [1] armed, [10:2] first_sensor_temp, [19:11] second_sensor_temp,
   // [23:20] zero
   input  wire logic [23:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] weld_drive, [1] busy_res, [2] overheated, [5:3] phase, [7:6] zero
   output logic [7:0]       rsp_tdata,

   input  wire logic        csr_wen,
   input  wire dpws_pkg::csr_index_type csr_index,
   input  wire logic [dpws_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import dpws_pkg::*;

   localparam int LEN_W = (TIMER_BITS > CSR_DATA_W) ? TIMER_BITS : CSR_DATA_W;
   localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

   // CSRs
   logic [9:0]               pre_delay_ff;
   logic [8:0]               first_pulse_ff;
   logic [8:0]               gap_ff;
   logic [8:0]               second_pulse_ff;
   logic [9:0]               holdoff_ff;
   logic signed [TEMP_W-1:0] first_limit_ff;
   logic signed [TEMP_W-1:0] second_limit_ff;

   // Sequencer state
   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   count_ff, count_in;

   // Output register
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_data_ff, rsp_data_in;

   req_word_type            req_word;
   logic                    req_fire;
   logic                    hot;
   logic [TIMER_BITS-1:0]   len [1:5];
   logic [5:1]              nonzero;
   logic [TIMER_BITS-1:0]   cur_len;

   // Clamp a phase length to what the counter can reach
   function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [CSR_DATA_W-1:0] raw);
      logic [LEN_W-1:0] ext;
      ext = LEN_W'(raw);
      if (ext > LEN_W'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return TIMER_BITS'(ext);
   endfunction

   // First non-empty phase after p, or idle
   function automatic phase_type next_phase(input phase_type p, input logic [5:1] nz);
      phase_type q;
      logic      found;
      q     = PH_IDLE;
      found = 1'b0;
      for (int i = 1; i <= 5; i++) begin
         if (!found && (3'(i) > p) && nz[i]) begin
            q     = 3'(i);
            found = 1'b1;
         end
      end
      return q;
   endfunction

   assign req_word   = req_word_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign len[1] = clamp_len(pre_delay_ff);
   assign len[2] = clamp_len({1'b0, first_pulse_ff});
   assign len[3] = clamp_len({1'b0, gap_ff});
   assign len[4] = clamp_len({1'b0, second_pulse_ff});
   assign len[5] = clamp_len(holdoff_ff);

   always_comb begin
      for (int i = 1; i <= 5; i++) begin
         nonzero[i] = (len[i] != '0);
      end
   end

   always_comb begin
      case (phase_ff)
         PH_PREDELAY: cur_len = len[1];
         PH_PULSE1:   cur_len = len[2];
         PH_GAP:      cur_len = len[3];
         PH_PULSE2:   cur_len = len[4];
         PH_HOLDOFF:  cur_len = len[5];
         default:     cur_len = '0;
      endcase
   end

   // Tick update: idle ticks check temperature and trigger, running ticks count and move on to the next phase
   always_comb begin
      hot      = 1'b0;
      phase_in = phase_ff;
      count_in = count_ff;
      if (phase_ff == PH_IDLE || phase_ff > PH_HOLDOFF) begin
         hot = (req_word.first_sensor_temp > first_limit_ff)
            || (req_word.second_sensor_temp > second_limit_ff);
         phase_in = PH_IDLE;
         count_in = '0;
         if (!hot && req_word.armed && req_word.trigger) begin
            phase_in = next_phase(PH_IDLE, nonzero);
            count_in = (phase_in != PH_IDLE) ? TIMER_BITS'(1) : '0;
         end
      end else if (count_ff < cur_len) begin
         count_in = count_ff + TIMER_BITS'(1);
      end else begin
         // phase done, move on; a shortened length also lands here
         phase_in = next_phase(phase_ff, nonzero);
         count_in = (phase_in != PH_IDLE) ? TIMER_BITS'(1) : '0;
      end
   end

   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.weld_drive = (phase_in == PH_PULSE1) || (phase_in == PH_PULSE2);
      rsp_data_in.busy_res   = (phase_in != PH_IDLE);
      rsp_data_in.overheated = hot;
      rsp_data_in.phase      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // CSR writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_delay_ff    <= RST_PRE_DELAY;
         first_pulse_ff  <= RST_FIRST_PULSE;
         gap_ff          <= RST_GAP;
         second_pulse_ff <= RST_SECOND_PULSE;
         holdoff_ff      <= RST_HOLDOFF;
         first_limit_ff  <= RST_FIRST_LIMIT;
         second_limit_ff <= RST_SECOND_LIMIT;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PRE_DELAY:    pre_delay_ff    <= csr_wdata;
            CSR_FIRST_PULSE:  first_pulse_ff  <= csr_wdata[8:0];
            CSR_GAP:          gap_ff          <= csr_wdata[8:0];
            CSR_SECOND_PULSE: second_pulse_ff <= csr_wdata[8:0];
            CSR_HOLDOFF:      holdoff_ff      <= csr_wdata;
            CSR_FIRST_LIMIT:  first_limit_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_SECOND_LIMIT: second_limit_ff <= csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // Counter is zero exactly when idle
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (count_ff == '0))
      else $error("tick counter out of step with phase");

   // Phase code never leaves the legal set
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_HOLDOFF)
      else $error("phase code out of range");

   // Overheat is only reported on a tick that stays idle
   a_hot_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && hot) |=> (phase_ff == PH_IDLE) && !rsp_data_ff.busy_res)
      else $error("weld started while overheated");

   // Drive only during a pulse of a running sequence
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.weld_drive |->
         rsp_data_ff.busy_res && !rsp_data_ff.overheated)
      else $error("weld drive outside a pulse");
`endif

endmodule

`default_nettype wire
